/* rtl/core/per_type_slot_byte_budget_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the per-type slot byte budget
// Concurrent checks clocked on clk_i and switched off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef PER_TYPE_SLOT_BYTE_BUDGET_MACROS_SVH
`define PER_TYPE_SLOT_BYTE_BUDGET_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define PSTB_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define PSTB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/pstb_pkg.sv */
// ----------------------------------------------------------------------------
// pstb_pkg
// Shared sizes, table entry layout and handshake structs of the budget block.
// ----------------------------------------------------------------------------
package pstb_pkg;

  // Table depth and address width
  localparam int unsigned NUM_TYPES = 1024;
  localparam int unsigned IDX_W     = $clog2(NUM_TYPES);

  // Field widths
  localparam int unsigned TYPE_W  = 10;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned LEN_W   = 32;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned FILL_W  = 16;
  localparam int unsigned LIMIT_W = 16;
  localparam int unsigned HDR_W   = 8;

  // Stream word widths, rounded up to whole bytes
  localparam int unsigned IN_BITS  = TYPE_W + TIME_W + LEN_W;
  localparam int unsigned OUT_BITS = 2 + CNT_W + CNT_W + FILL_W;
  localparam int unsigned IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_BYTE_LIMIT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_BYTES    = CFG_IDX_W'(1);
  localparam logic [LIMIT_W-1:0]   LIMIT_RESET         = LIMIT_W'(2048);
  localparam logic [HDR_W-1:0]     HEADER_RESET        = HDR_W'(12);

  // One table entry
  typedef struct packed {
    logic [CNT_W-1:0]  msg_count;
    logic [CNT_W-1:0]  slot_count;
    logic [FILL_W-1:0] fill;
    logic [TIME_W-1:0] slot_time;
  } pstb_entry_t;

  // Table write port
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  addr;
    pstb_entry_t       data;
  } pstb_wr_t;

  // Outcome of one message
  typedef struct packed {
    logic        wr;
    logic        accepted;
    logic        opened;
    pstb_entry_t entry;
  } pstb_upd_t;

  // Saturating increment of a counter
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (&v) ? v : v + CNT_W'(1);
  endfunction

endpackage

/* rtl/core/pstb_table.sv */
// ----------------------------------------------------------------------------
// pstb_table
// Per-type state memory: one read port with registered data, one write
// port, and a clearing sweep over every entry after reset.
// ----------------------------------------------------------------------------
module pstb_table
  import pstb_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [IDX_W-1:0] rd_addr_i,
  output pstb_entry_t      rd_data_o,
  input  pstb_wr_t         wr_i,
  output logic             clr_done_o
);

  pstb_entry_t mem [NUM_TYPES];

  logic [IDX_W:0] clr_cnt_q, clr_cnt_d;
  logic           clr_done_q, clr_done_d;
  pstb_entry_t    rd_data_q;
  pstb_wr_t       port;

  // Sweep one entry a cycle until the whole table is zero
  always_comb begin
    clr_cnt_d  = clr_cnt_q;
    clr_done_d = clr_done_q;
    if (!clr_done_q) begin
      clr_cnt_d = clr_cnt_q + (IDX_W + 1)'(1);
      if (clr_cnt_q == (IDX_W + 1)'(NUM_TYPES - 1)) begin
        clr_done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q  <= '0;
      clr_done_q <= 1'b0;
    end else begin
      clr_cnt_q  <= clr_cnt_d;
      clr_done_q <= clr_done_d;
    end
  end

  // Steer the write port to the sweep while it runs
  always_comb begin
    if (!clr_done_q) begin
      port.en   = 1'b1;
      port.addr = clr_cnt_q[IDX_W-1:0];
      port.data = '0;
    end else begin
      port = wr_i;
    end
  end

  // Write and read the memory
  always_ff @(posedge clk_i) begin
    if (port.en) begin
      mem[port.addr] <= port.data;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o  = rd_data_q;
  assign clr_done_o = clr_done_q;

`include "per_type_slot_byte_budget_macros.svh"

  `PSTB_ASSERT_NEXT(a_clr_done_sticky, clr_done_q, clr_done_q, "sweep restarted after finishing")
  `PSTB_ASSERT_SAME(a_no_wr_in_sweep, wr_i.en, clr_done_q, "table written during the sweep")
  `PSTB_ASSERT_SAME(a_no_rd_in_sweep, rd_en_i, clr_done_q, "table read during the sweep")

endmodule

/* rtl/core/pstb_update.sv */
// ----------------------------------------------------------------------------
// pstb_update
// Budget decision and new entry for one message, from the entry just read.
// ----------------------------------------------------------------------------
module pstb_update
  import pstb_pkg::*;
(
  input  pstb_entry_t        entry_i,
  input  logic               in_range_i,
  input  logic [TIME_W-1:0]  msg_time_i,
  input  logic [LEN_W-1:0]   payload_length_i,
  input  logic [LIMIT_W-1:0] slot_byte_limit_i,
  input  logic [HDR_W-1:0]   header_bytes_i,
  output pstb_upd_t          upd_o
);

  logic [FILL_W-1:0] fill_base;
  logic [LEN_W:0]    msg_size;
  logic [LEN_W+1:0]  fill_sum;
  logic              fits;
  logic              opens;

  // Drop the slot fill when a known type moves to another slot time
  assign fill_base = ((entry_i.msg_count != '0) && (entry_i.slot_time != msg_time_i))
                     ? '0 : entry_i.fill;

  // Size and budget check, kept wide so huge payloads never wrap
  assign msg_size = (LEN_W + 1)'(header_bytes_i) + (LEN_W + 1)'(payload_length_i);
  assign fill_sum = (LEN_W + 2)'(fill_base) + (LEN_W + 2)'(msg_size);
  assign fits     = fill_sum <= (LEN_W + 2)'(slot_byte_limit_i);
  assign opens    = fits && (fill_base == '0);

  // Build the entry to write back; out-of-table types give all zero
  always_comb begin
    upd_o = '0;
    if (in_range_i) begin
      upd_o.wr                = 1'b1;
      upd_o.accepted          = fits;
      upd_o.opened            = opens;
      upd_o.entry             = entry_i;
      upd_o.entry.fill        = fill_base;
      if (fits) begin
        upd_o.entry.slot_time = msg_time_i;
        upd_o.entry.fill      = fill_sum[FILL_W-1:0];
        upd_o.entry.msg_count = sat_inc(entry_i.msg_count);
        if (opens) begin
          upd_o.entry.slot_count = sat_inc(entry_i.slot_count);
        end
      end
    end
  end

endmodule

/* rtl/core/per_type_slot_byte_budget.sv */
// ----------------------------------------------------------------------------
// per_type_slot_byte_budget
// Per-type byte budget per time slot over a stream of message headers.
// ----------------------------------------------------------------------------
// Each message header is taken in S_IDLE, where the read of its type's
// table entry is issued; in S_READ the decision is written back to the
// table and into the output register, after which a new header is taken.
// The registered read data of the state memory, with no new header
// taken before the write-back, makes the block take one header at a time.
// A result waiting at the output holds the block only when the following
// header is ready to finish. After reset the block clears the table and
// then leaves the clearing state, and takes no header during that time;
// configuration writes are taken at any time.
module per_type_slot_byte_budget
  import pstb_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // message headers in
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_W-1:0]       s_axis_tdata,  // msg_type, msg_time, payload_length
  // results out
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_W-1:0]      m_axis_tdata   // accepted, opened_slot,
                                               // type_message_total,
                                               // type_slot_total, slot_fill
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_READ
  } state_e;

  state_e             state_q, state_d;
  logic [TYPE_W-1:0]  type_q, type_d;
  logic [TIME_W-1:0]  time_q, time_d;
  logic [LEN_W-1:0]   plen_q, plen_d;
  logic               out_valid_q, out_valid_d;
  logic [OUT_W-1:0]   out_word_q, out_word_d;
  logic [LIMIT_W-1:0] limit_q;
  logic [HDR_W-1:0]   header_q;

  logic               in_word;
  logic               out_free;
  logic               finish;
  logic               clr_done;
  logic               in_range;
  pstb_entry_t        rd_data;
  pstb_wr_t           wr;
  pstb_upd_t          upd;

  assign in_word  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign finish   = (state_q == S_READ) && out_free;
  assign in_range = 32'(type_q) < NUM_TYPES;

  // Hold the two budget registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q  <= LIMIT_RESET;
      header_q <= HEADER_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SLOT_BYTE_LIMIT: limit_q  <= cfg_data_i[LIMIT_W-1:0];
        REG_HEADER_BYTES:    header_q <= cfg_data_i[HDR_W-1:0];
        default:             ;
      endcase
    end
  end

  pstb_table u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (in_word),
    .rd_addr_i  (IDX_W'(s_axis_tdata[TYPE_W-1:0])),
    .rd_data_o  (rd_data),
    .wr_i       (wr),
    .clr_done_o (clr_done)
  );

  pstb_update u_update (
    .entry_i           (rd_data),
    .in_range_i        (in_range),
    .msg_time_i        (time_q),
    .payload_length_i  (plen_q),
    .slot_byte_limit_i (limit_q),
    .header_bytes_i    (header_q),
    .upd_o             (upd)
  );

  // Write the new entry back as the result leaves for the output register
  assign wr.en   = finish && upd.wr;
  assign wr.addr = IDX_W'(type_q);
  assign wr.data = upd.entry;

  // Sequence one header at a time
  always_comb begin
    state_d     = state_q;
    type_d      = type_q;
    time_d      = time_q;
    plen_d      = plen_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_word_d  = out_word_q;
    case (state_q)
      S_CLEAR: begin
        if (clr_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_word) begin
          type_d  = s_axis_tdata[TYPE_W-1:0];
          time_d  = s_axis_tdata[TYPE_W +: TIME_W];
          plen_d  = s_axis_tdata[TYPE_W+TIME_W +: LEN_W];
          state_d = S_READ;
        end
      end
      S_READ: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_word_d  = OUT_W'({upd.entry.fill, upd.entry.slot_count,
                                upd.entry.msg_count, upd.opened, upd.accepted});
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      type_q      <= '0;
      time_q      <= '0;
      plen_q      <= '0;
      out_valid_q <= 1'b0;
      out_word_q  <= '0;
    end else begin
      state_q     <= state_d;
      type_q      <= type_d;
      time_q      <= time_d;
      plen_q      <= plen_d;
      out_valid_q <= out_valid_d;
      out_word_q  <= out_word_d;
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_word_q;

`include "per_type_slot_byte_budget_macros.svh"

  `PSTB_ASSERT_NEXT(a_take_then_read, in_word, state_q == S_READ && out_valid_q == $past(out_valid_q && !m_axis_tready), "header taken without a table read")
  `PSTB_ASSERT_SAME(a_wr_only_on_finish, wr.en, state_q == S_READ && out_free, "table written outside write-back")
  `PSTB_ASSERT_NEXT(a_finish_gives_word, finish, out_valid_q && state_q == S_IDLE, "finished header left no result")
  `PSTB_ASSERT_SAME(a_no_take_in_sweep, !clr_done, !s_axis_tready, "header taken while the table is clearing")

endmodule
